@@ hw/rtl/cbsm_pkg.sv @@
`timescale 1ns / 1ps

package cbsm_pkg;

   // Default bank size in kilobytes
   localparam int BANK_KB_DEFAULT = 16;

   localparam int ADDR_W     = 16;
   localparam int DATA_W     = 8;
   localparam int BANK_W     = 8;
   localparam int ROM_KB_W   = 13;
   localparam int OFFSET_W   = 12;
   localparam int CART_W     = 3;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 40;

   localparam logic [ADDR_W-1:0] WIN_LOW        = 16'h4000;
   localparam logic [ADDR_W-1:0] WIN_MID        = 16'h8000;
   localparam logic [ADDR_W-1:0] WIN_HIGH_LIMIT = 16'hC000;
   localparam logic [ADDR_W-1:0] WIN_ALT        = 16'hA000;
   localparam logic [ADDR_W-1:0] HOT_ZONE       = 16'hFF80;
   localparam logic [ADDR_W-1:0] NO_WINDOW      = 16'h0000;
   localparam logic [ROM_KB_W-1:0] ROM_SMALL_KB = 13'd64;

   typedef enum logic [CART_W-1:0] {
      CART_NORMAL     = 3'd0,
      CART_NORMAL_RAM = 3'd1,
      CART_SUPER      = 3'd2,
      CART_SUPER_RAM  = 3'd3,
      CART_SUPER_ROM  = 3'd4,
      CART_LARGE      = 3'd5,
      CART_ABSOLUTE   = 3'd6,
      CART_HOTSPOT    = 3'd7
   } cart_type_type;

   typedef enum logic {
      CSR_CART_TYPE   = 1'b0,
      CSR_ROM_SIZE_KB = 1'b1
   } csr_index_type;

endpackage

@@ hw/rtl/cartridge_bank_switch_mapper_unit.sv @@
`timescale 1ns / 1ps

// Cartridge bank-switch mapper. Each request is one CPU write (address, data
// byte); each produces exactly one response giving the switch flag, the bank
// now held, the CPU base of the switched window and the bank's ROM offset in
// kilobytes. It takes one request per clock cycle unless stalled and presents its
// response in the next cycle from a single response register; bank_ff updates at
// the same edge. While a response is stalled (rsp_tready low) req_tready drops in
// the same cycle. The user writes cart_type and rom_size_kb through the csr_ port
// while no request is in flight; the block does not enforce this.
module cartridge_bank_switch_mapper_unit #(
   parameter int BANK_KB = cbsm_pkg::BANK_KB_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // req_tdata: cpu_address[15:0], write_data[23:16]
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [cbsm_pkg::REQ_DATA_W-1:0]      req_tdata,
   // rsp_tdata: switched[0], current_bank[8:1], window_base[24:9],
   //            bank_offset_kb[36:25], zero[39:37]
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [cbsm_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   input  logic                                 csr_we,
   input  logic                                 csr_index,
   input  logic [cbsm_pkg::ROM_KB_W-1:0]        csr_wdata
);

   localparam int PROD_W = $clog2(256 * BANK_KB + 1);
   localparam int CMP_W  = (PROD_W > cbsm_pkg::ROM_KB_W) ? PROD_W : cbsm_pkg::ROM_KB_W;
   localparam logic [CMP_W-1:0] BANK_KB_C = CMP_W'(BANK_KB);

   cbsm_pkg::cart_type_type            cart_type_ff;
   logic [cbsm_pkg::ROM_KB_W-1:0]      rom_size_ff;
   logic [cbsm_pkg::BANK_W-1:0]        bank_ff, bank_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [cbsm_pkg::RSP_DATA_W-1:0]    rsp_data_ff, rsp_data_in;

   logic                               req_accept;
   logic [cbsm_pkg::ADDR_W-1:0]        addr;
   logic [cbsm_pkg::DATA_W-1:0]        data;
   logic                               plain_super, small_rom, mask_bank, in_win;
   logic [CMP_W-1:0]                   rom_ext;
   logic [cbsm_pkg::BANK_W-1:0]        eff_data, data_inc, eff_bank;
   logic [CMP_W-1:0]                   upper_data, upper_raw, low_inc, low_abs, low_hot, off_prod;
   logic                               sw;
   logic [cbsm_pkg::ADDR_W-1:0]        base;
   logic [cbsm_pkg::BANK_W-1:0]        abs_bank, hot_bank;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign addr = req_tdata[15:0];
   assign data = req_tdata[23:16];

   always_comb begin
      plain_super = (cart_type_ff inside {cbsm_pkg::CART_SUPER, cbsm_pkg::CART_SUPER_RAM,
                                          cbsm_pkg::CART_SUPER_ROM});
      small_rom   = rom_size_ff <= cbsm_pkg::ROM_SMALL_KB;
      mask_bank   = plain_super && small_rom;
      in_win      = (addr >= cbsm_pkg::WIN_MID) && (addr < cbsm_pkg::WIN_HIGH_LIMIT);
      rom_ext     = CMP_W'(rom_size_ff);

      eff_data = mask_bank ? {6'd0, data[1:0]} : data;
      data_inc = data + 8'd1;
      abs_bank = data - 8'd1;
      hot_bank = {5'd0, addr[2:0]};

      // (bank + 1) * size <= rom is the same as bank < rom / size
      upper_data = (CMP_W'(eff_data) + CMP_W'(1)) * BANK_KB_C;
      upper_raw  = (CMP_W'(data) + CMP_W'(1)) * BANK_KB_C;
      low_inc    = CMP_W'(data_inc) * BANK_KB_C;
      low_abs    = CMP_W'(abs_bank) * BANK_KB_C;
      low_hot    = CMP_W'(hot_bank) * BANK_KB_C;

      sw      = 1'b0;
      base    = cbsm_pkg::NO_WINDOW;
      bank_in = bank_ff;
      case (cart_type_ff)
         cbsm_pkg::CART_SUPER, cbsm_pkg::CART_SUPER_RAM, cbsm_pkg::CART_SUPER_ROM: begin
            if (in_win && upper_data <= rom_ext) begin
               sw      = 1'b1;
               base    = cbsm_pkg::WIN_MID;
               bank_in = data;
            end
         end
         cbsm_pkg::CART_LARGE: begin
            // store the bank after the one written
            if (in_win && upper_raw <= rom_ext && low_inc < rom_ext) begin
               sw      = 1'b1;
               base    = cbsm_pkg::WIN_MID;
               bank_in = data_inc;
            end
         end
         cbsm_pkg::CART_ABSOLUTE: begin
            if (addr == cbsm_pkg::WIN_MID && (data == 8'd1 || data == 8'd2)
                && low_abs < rom_ext) begin
               sw      = 1'b1;
               base    = cbsm_pkg::WIN_LOW;
               bank_in = abs_bank;
            end
         end
         cbsm_pkg::CART_HOTSPOT: begin
            if (addr >= cbsm_pkg::HOT_ZONE && low_hot < rom_ext) begin
               sw      = 1'b1;
               base    = cbsm_pkg::WIN_ALT;
               bank_in = hot_bank;
            end
         end
         default: begin
         end
      endcase

      eff_bank = mask_bank ? {6'd0, bank_in[1:0]} : bank_in;
      off_prod = CMP_W'(eff_bank) * BANK_KB_C;

      rsp_data_in = {3'd0, off_prod[cbsm_pkg::OFFSET_W-1:0], base, bank_in, sw};
      rsp_valid_in = req_accept ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cart_type_ff <= cbsm_pkg::CART_NORMAL;
         rom_size_ff  <= '0;
         bank_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_accept) begin
            bank_ff <= bank_in;
         end
         if (csr_we) begin
            case (csr_index)
               cbsm_pkg::CSR_CART_TYPE:
                  cart_type_ff <= cbsm_pkg::cart_type_type'(csr_wdata[cbsm_pkg::CART_W-1:0]);
               cbsm_pkg::CSR_ROM_SIZE_KB:
                  rom_size_ff  <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   // hold the response while stalled
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule
